[rtl/ppd_pkg.sv]
package ppd_pkg;

   localparam int CLAMP_LIMIT = 20000;
   localparam int NEAR_SQ = 4;
   localparam int VP_LEFT = -50;
   localparam int VP_RIGHT = 590;
   localparam int VP_TOP = -50;
   localparam int VP_BOTTOM = 1010;
   localparam logic signed [15:0] LAST_RESET = -16'sd30000;

   typedef enum logic [2:0] {
      REG_INVERSE_SCALE = 3'd0,
      REG_TILE_ORIGIN_X = 3'd1,
      REG_TILE_ORIGIN_Y = 3'd2,
      REG_ROTATION_COS  = 3'd3,
      REG_ROTATION_SIN  = 3'd4,
      REG_CENTER_X      = 3'd5,
      REG_CENTER_Y      = 3'd6,
      REG_SHED_MASK     = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      VERDICT_KEPT      = 2'd0,
      VERDICT_OFFSCREEN = 2'd1,
      VERDICT_FEW       = 2'd2,
      VERDICT_SHED      = 2'd3
   } verdict_type;

   typedef enum logic {
      KIND_POINT   = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [17:0]        inverse_scale;
      logic signed [31:0] tile_origin_x;
      logic signed [31:0] tile_origin_y;
      logic signed [15:0] rotation_cos;
      logic signed [15:0] rotation_sin;
      logic [9:0]         screen_center_x;
      logic [9:0]         screen_center_y;
      logic [6:0]         shed_class_mask;
   } cfg_type;

   // One projected vertex handed from the front part to the back part.
   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               first;
      logic               last;
      logic               shed;
   } work_type;

endpackage

[rtl/ppd_if.sv]
interface ppd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vertex_east;
   logic signed [15:0] vertex_north;
   logic [2:0]         feature_class;
   logic               first_vertex;
   logic               last_vertex;
   modport source(output valid, vertex_east, vertex_north, feature_class, first_vertex,
                  last_vertex, input ready);
   modport sink(input valid, vertex_east, vertex_north, feature_class, first_vertex,
                last_vertex, output ready);
endinterface

interface ppd_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;
   logic [1:0]         verdict;
   logic [15:0]        kept_points;
   logic               run_last;
   modport source(output valid, result_kind, screen_x, screen_y, verdict, kept_points,
                  run_last, input ready);
   modport sink(input valid, result_kind, screen_x, screen_y, verdict, kept_points,
                run_last, output ready);
endinterface

[rtl/ppd_front.sv]
module ppd_front (
   input  logic                clock,
   input  logic                reset,
   input  ppd_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [15:0]  in_east,
   input  logic signed [15:0]  in_north,
   input  logic [2:0]          in_class,
   input  logic                in_first,
   input  logic                in_last,
   output logic                out_valid,
   input  logic                out_ready,
   output ppd_pkg::work_type   out_work
);

   // Stage 1: scale and offset. Stage 2: rotation products. Stage 3: sum, clamp, round.
   logic               v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic               shed_ff, shed_in;
   logic signed [50:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [67:0] xc_ff, xc_in, xs_ff, xs_in, yc_ff, yc_in, ys_ff, ys_in;
   logic [9:0]         cx2_ff, cy2_ff;
   logic [2:0]         f1_ff, f2_ff;
   ppd_pkg::work_type  w3_ff, w3_in;
   logic               adv;
   logic               shed_now;
   logic signed [69:0] sum_x, sum_y;

   assign adv = !v3_ff || out_ready;
   assign in_ready = adv;
   assign out_valid = v3_ff;
   assign out_work = w3_ff;

   function automatic logic signed [15:0] to_pixel(input logic signed [69:0] v);
      logic signed [69:0] lim, c;
      logic [69:0]        mag;
      lim = 70'sd20000 <<< 30;
      c = v;
      if (c > lim) c = lim;
      if (c < -lim) c = -lim;
      if (c >= 0) begin
         mag = (70'(c) + (70'd1 << 29)) >> 30;
         to_pixel = 16'(mag);
      end else begin
         mag = (70'(-c) + (70'd1 << 29)) >> 30;
         to_pixel = -16'(mag);
      end
   endfunction

   always_comb begin
      shed_now = in_first && in_class != 3'd7 && cfg.shed_class_mask[in_class];
      shed_in = shed_ff;
      if (in_valid && adv) begin
         if (in_first) shed_in = shed_now;
         else shed_in = shed_ff;
         if (in_last) shed_in = 1'b0;
      end
      v1_in = in_valid;
      dx_in = (51'(cfg.tile_origin_x) <<< 8) + 51'(in_east * $signed({1'b0, cfg.inverse_scale}))
              - $signed({25'd0, cfg.screen_center_x, 16'd0});
      dy_in = (51'(cfg.tile_origin_y) <<< 8) - 51'(in_north * $signed({1'b0, cfg.inverse_scale}))
              - $signed({25'd0, cfg.screen_center_y, 16'd0});
      v2_in = v1_ff;
      xc_in = 68'(dx_ff * cfg.rotation_cos);
      xs_in = 68'(dy_ff * cfg.rotation_sin);
      yc_in = 68'(dy_ff * cfg.rotation_cos);
      ys_in = 68'(dx_ff * cfg.rotation_sin);
      v3_in = v2_ff;
      sum_x = $signed({30'd0, cx2_ff, 30'd0}) + 70'(xc_ff) - 70'(xs_ff);
      sum_y = $signed({30'd0, cy2_ff, 30'd0}) + 70'(ys_ff) + 70'(yc_ff);
      w3_in.px = to_pixel(sum_x);
      w3_in.py = to_pixel(sum_y);
      w3_in.first = f2_ff[2];
      w3_in.last = f2_ff[1];
      w3_in.shed = f2_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         shed_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         shed_ff <= shed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         f1_ff <= {in_first, in_last, in_first ? shed_now : shed_ff};
         xc_ff <= xc_in;
         xs_ff <= xs_in;
         yc_ff <= yc_in;
         ys_ff <= ys_in;
         cx2_ff <= cfg.screen_center_x;
         cy2_ff <= cfg.screen_center_y;
         f2_ff <= f1_ff;
         w3_ff <= w3_in;
      end
   end

endmodule

[rtl/ppd_queue.sv]
module ppd_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ppd_pkg::work_type in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output ppd_pkg::work_type out_work
);

   localparam int AW = $clog2(DEPTH);

   ppd_pkg::work_type        mem_ff [DEPTH];
   logic [AW-1:0]            wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]              cnt_ff, cnt_in;
   logic                     push, pop;

   assign in_ready = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_work = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wp_in = push ? ((wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in = pop ? ((rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_work;
   end

endmodule

[rtl/ppd_back.sv]
module ppd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ppd_pkg::work_type  in_work,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               out_kind,
   output logic signed [15:0] out_x,
   output logic signed [15:0] out_y,
   output logic [1:0]         out_verdict,
   output logic [15:0]        out_kept,
   output logic               out_last
);

   logic signed [15:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic               reach_ff, reach_in;
   logic               pend_ff, pend_in;
   logic               ov_ff, ov_in;
   logic               kind_ff, kind_in, rl_ff, rl_in;
   logic signed [15:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [1:0]         ovd_ff, ovd_in;
   logic [15:0]        ok_ff, ok_in;
   logic [15:0]        pk_ff, pk_in;
   logic [1:0]         pv_ff, pv_in;
   logic signed [15:0] cbx, cby, ibx, iby, lox, hix, loy, hiy;
   logic signed [16:0] ax, ay;
   logic [33:0]        d2;
   logic               keep, take, slot_free, meets;
   logic [15:0]        cnt_k;
   logic               reach_k;

   assign slot_free = !ov_ff || out_ready;
   assign in_ready = slot_free && !pend_ff;
   assign take = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_kind = kind_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_verdict = ovd_ff;
   assign out_kept = ok_ff;
   assign out_last = rl_ff;

   always_comb begin
      cbx = in_work.first ? ppd_pkg::LAST_RESET : lx_ff;
      cby = in_work.first ? ppd_pkg::LAST_RESET : ly_ff;
      cnt_k = in_work.first ? 16'd0 : cnt_ff;
      reach_k = in_work.first ? 1'b0 : reach_ff;
      ibx = in_work.px;
      iby = in_work.py;
      ax = 17'(ibx) - 17'(cbx);
      ay = 17'(iby) - 17'(cby);
      d2 = 34'(ax * ax) + 34'(ay * ay);
      keep = !in_work.shed && !(cnt_k != 0 && !in_work.last && d2 < 34'(ppd_pkg::NEAR_SQ));
      lox = cbx < ibx ? cbx : ibx;
      hix = cbx < ibx ? ibx : cbx;
      loy = cby < iby ? cby : iby;
      hiy = cby < iby ? iby : cby;
      meets = hix > 16'(ppd_pkg::VP_LEFT) && lox < 16'(ppd_pkg::VP_RIGHT)
              && hiy > 16'(ppd_pkg::VP_TOP) && loy < 16'(ppd_pkg::VP_BOTTOM);
      lx_in = lx_ff; ly_in = ly_ff; cnt_in = cnt_ff; reach_in = reach_ff;
      pend_in = pend_ff; pk_in = pk_ff; pv_in = pv_ff;
      ov_in = ov_ff && !out_ready;
      kind_in = kind_ff; ox_in = ox_ff; oy_in = oy_ff; ovd_in = ovd_ff; ok_in = ok_ff;
      rl_in = rl_ff;
      if (pend_ff && slot_free) begin
         pend_in = 1'b0;
         ov_in = 1'b1;
         kind_in = ppd_pkg::KIND_VERDICT;
         ox_in = '0; oy_in = '0; ovd_in = pv_ff; ok_in = pk_ff; rl_in = 1'b1;
      end else if (take) begin
         lx_in = cbx; ly_in = cby; cnt_in = cnt_k; reach_in = reach_k;
         if (keep) begin
            if (cnt_k != 0 && meets) reach_in = 1'b1;
            lx_in = ibx; ly_in = iby;
            if (cnt_k != 16'hFFFF) cnt_in = cnt_k + 16'd1;
         end
         if (in_work.shed) pv_in = ppd_pkg::VERDICT_SHED;
         else if (cnt_in < 16'd2) pv_in = ppd_pkg::VERDICT_FEW;
         else if (!reach_in) pv_in = ppd_pkg::VERDICT_OFFSCREEN;
         else pv_in = ppd_pkg::VERDICT_KEPT;
         pk_in = in_work.shed ? 16'd0 : cnt_in;
         if (keep) begin
            ov_in = 1'b1;
            kind_in = ppd_pkg::KIND_POINT;
            ox_in = ibx; oy_in = iby; ovd_in = '0; ok_in = '0;
            rl_in = !in_work.last;
            pend_in = in_work.last;
         end else if (in_work.last) begin
            ov_in = 1'b1;
            kind_in = ppd_pkg::KIND_VERDICT;
            ox_in = '0; oy_in = '0; ovd_in = pv_in; ok_in = pk_in; rl_in = 1'b1;
         end
         if (in_work.last) begin
            lx_in = ppd_pkg::LAST_RESET; ly_in = ppd_pkg::LAST_RESET;
            cnt_in = '0; reach_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff <= ppd_pkg::LAST_RESET;
         ly_ff <= ppd_pkg::LAST_RESET;
         cnt_ff <= '0;
         reach_ff <= 1'b0;
         pend_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         cnt_ff <= cnt_in;
         reach_ff <= reach_in;
         pend_ff <= pend_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      ovd_ff <= ovd_in;
      ok_ff <= ok_in;
      rl_ff <= rl_in;
      pk_ff <= pk_in;
      pv_ff <= pv_in;
   end

endmodule

[rtl/polyline_project_decimate.sv]
// Projects road polyline vertices to screen pixels and drops near duplicates.
// The req channel carries one vertex per item with its first and last marks;
// the rsp channel carries kept points and, after a feature's last vertex,
// one verdict item with the kept count. Items move when valid and ready are high.
// The csr port writes one register per cycle and must only be used while idle.
// A vertex passes a three-stage projection pipeline (scale and offset,
// rotation products, sum with clamp and rounding), a small queue, and the
// decimation stage, which registers each result.
// One vertex is accepted per cycle while nothing stalls; a last vertex that is
// kept yields two items and holds the decimation stage until its verdict item is registered.
// Reset restores the configuration to its defaults, clears the valid flags and clears the feature state.
// When the receiver stalls, the output register holds, the queue fills and
// then the projection pipeline and req ready stall; nothing is lost.
module polyline_project_decimate #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   ppd_req_if.sink     req,
   ppd_rsp_if.source   rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   ppd_pkg::cfg_type  cfg_ff, cfg_in;
   logic              fq_valid, fq_ready, qb_valid, qb_ready;
   ppd_pkg::work_type fq_work, qb_work;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (ppd_pkg::reg_index_type'(csr_index))
            ppd_pkg::REG_INVERSE_SCALE: cfg_in.inverse_scale = csr_data[17:0];
            ppd_pkg::REG_TILE_ORIGIN_X: cfg_in.tile_origin_x = csr_data;
            ppd_pkg::REG_TILE_ORIGIN_Y: cfg_in.tile_origin_y = csr_data;
            ppd_pkg::REG_ROTATION_COS:  cfg_in.rotation_cos = csr_data[15:0];
            ppd_pkg::REG_ROTATION_SIN:  cfg_in.rotation_sin = csr_data[15:0];
            ppd_pkg::REG_CENTER_X:      cfg_in.screen_center_x = csr_data[9:0];
            ppd_pkg::REG_CENTER_Y:      cfg_in.screen_center_y = csr_data[9:0];
            ppd_pkg::REG_SHED_MASK:     cfg_in.shed_class_mask = csr_data[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inverse_scale <= 18'd65536;
         cfg_ff.tile_origin_x <= '0;
         cfg_ff.tile_origin_y <= '0;
         cfg_ff.rotation_cos <= 16'sd16384;
         cfg_ff.rotation_sin <= '0;
         cfg_ff.screen_center_x <= 10'd270;
         cfg_ff.screen_center_y <= 10'd480;
         cfg_ff.shed_class_mask <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppd_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_east(req.vertex_east), .in_north(req.vertex_north),
      .in_class(req.feature_class), .in_first(req.first_vertex), .in_last(req.last_vertex),
      .out_valid(fq_valid), .out_ready(fq_ready), .out_work(fq_work)
   );

   ppd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_work(fq_work),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_work(qb_work)
   );

   ppd_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(qb_valid), .in_ready(qb_ready), .in_work(qb_work),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_kind(rsp.result_kind),
      .out_x(rsp.screen_x), .out_y(rsp.screen_y), .out_verdict(rsp.verdict),
      .out_kept(rsp.kept_points), .out_last(rsp.run_last)
   );

endmodule
